// ===== src/beep_burst_sequencer_core_assert.svh =====
// Assertion macros for the beep burst sequencer checker.
`ifndef BEEP_BURST_SEQUENCER_CORE_ASSERT_SVH
`define BEEP_BURST_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbs assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbs assertion failed");

`endif

// ===== src/bbs_pkg.sv =====
// Types, codes and constants of the beep burst sequencer.
package bbs_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SOUND = 2'd1;
  localparam logic [1:0] REQ_TUNE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [7:0] TUNE_FOUR_BEEPS = 8'd0;
  localparam logic [7:0] TUNE_LONG_TONE  = 8'd1;
  localparam logic [7:0] TUNE_DOUBLE     = 8'd2;

  localparam logic [7:0] DUTY_LIMIT = 8'd100;
  localparam logic [7:0] TUNE_COUNT = 8'd3;

  // Division by 1000 is a shift by three and a division by 125, the latter done
  // with a reciprocal multiply and a single correction step.
  localparam int          DIV_PRE_SHIFT = 3;
  localparam int          RECIP_SHIFT   = 29;
  localparam logic [22:0] RECIP_M       = 23'd4294967;
  localparam logic [28:0] DIV_REST      = 29'd125;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  duty_percent;
    logic [15:0] tone_freq;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] repeat_total;
    logic [7:0]  tune_index;
    logic        power_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        busy_res;
    logic        power_enable;
    logic        pwm_fire;
    logic [6:0]  pwm_duty;
    logic [15:0] pwm_freq;
    logic [22:0] pwm_cycles;
    logic        adc_start;
  } result_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic [15:0] freq;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] rep;
  } pattern_t;

  function automatic pattern_t tune_lookup(input logic [7:0] idx);
    pattern_t p;
    p = '{duty: 8'd50, freq: 16'd2800, on_ms: 16'd100, off_ms: 16'd1000, rep: 16'd4};
    case (idx)
      TUNE_LONG_TONE: begin
        p.on_ms  = 16'd1000;
        p.off_ms = 16'd1;
        p.rep    = 16'd1;
      end
      TUNE_DOUBLE: begin
        p.on_ms  = 16'd50;
        p.off_ms = 16'd100;
        p.rep    = 16'd2;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

endpackage

// ===== src/bbs_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
interface bbs_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/bbs_cycles.sv =====
// Burst cycle count: product over 1000 by reciprocal multiply and correction.
module bbs_cycles import bbs_pkg::*; (
  input  logic        clk,
  input  logic [31:0] held_prod,
  output logic [22:0] cycles
);

  logic [28:0] x;
  logic [51:0] mr;
  logic [22:0] q0;
  logic [28:0] back;
  logic [28:0] rest;

  assign x = held_prod[31:DIV_PRE_SHIFT];

  always_ff @(posedge clk) begin
    mr <= 52'(x) * 52'(RECIP_M);
  end

  // The estimate is at most one short of the true quotient.
  always_comb begin
    q0     = mr[RECIP_SHIFT +: 23];
    back   = 29'(q0) * DIV_REST;
    rest   = x - back;
    cycles = q0 + 23'(rest >= DIV_REST);
  end

endmodule

// ===== src/bbs_seq.sv =====
// Pattern state and the per-beat update of the beep sequencer.
module bbs_seq import bbs_pkg::*; #(
  parameter int START_DELAY_MS = 10,
  parameter int TIME_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  item_t       item,
  input  logic        buzzer_enabled,
  input  logic [22:0] cycles,
  output logic [31:0] held_prod,
  output result_t     res
);

  logic                 playing, playing_next;
  logic                 next_is_burst, next_is_burst_next;
  logic [TIME_BITS-1:0] ms_left, ms_left_next;
  logic [15:0]          bursts_done, bursts_done_next;
  logic [15:0]          burst_limit, burst_limit_next;
  logic [6:0]           held_duty, held_duty_next;
  logic [15:0]          held_freq, held_freq_next;
  logic [15:0]          held_on_ms, held_on_ms_next;
  logic [15:0]          held_off_ms, held_off_ms_next;
  logic [31:0]          held_prod_next;
  pattern_t             pat;
  logic                 pat_ok;
  logic [1:0]           status;

  always_comb begin
    playing_next       = playing;
    next_is_burst_next = next_is_burst;
    ms_left_next       = ms_left;
    bursts_done_next   = bursts_done;
    burst_limit_next   = burst_limit;
    held_duty_next     = held_duty;
    held_freq_next     = held_freq;
    held_on_ms_next    = held_on_ms;
    held_off_ms_next   = held_off_ms;
    held_prod_next     = held_prod;
    res                = '0;
    status             = ST_OK;
    pat_ok             = 1'b1;
    pat = '{duty: item.duty_percent, freq: item.tone_freq, on_ms: item.on_ms,
            off_ms: item.off_ms, rep: item.repeat_total};
    if (item.req_type == REQ_TUNE) begin
      pat    = tune_lookup(item.tune_index);
      pat_ok = item.tune_index < TUNE_COUNT;
    end

    case (item.req_type)
      REQ_TICK: begin
        if (playing) begin
          if (ms_left > TIME_BITS'(1)) begin
            ms_left_next = ms_left - TIME_BITS'(1);
          end else if (!item.power_ok) begin
            playing_next = 1'b0;
            ms_left_next = '0;
          end else if (next_is_burst) begin
            next_is_burst_next = 1'b0;
            res.pwm_fire       = 1'b1;
            res.pwm_duty       = held_duty;
            res.pwm_freq       = held_freq;
            res.pwm_cycles     = cycles;
            ms_left_next       = TIME_BITS'(held_on_ms);
          end else begin
            next_is_burst_next = 1'b1;
            if (bursts_done < burst_limit) begin
              bursts_done_next = bursts_done + 16'd1;
              ms_left_next     = TIME_BITS'(held_off_ms);
            end else begin
              playing_next  = 1'b0;
              ms_left_next  = '0;
              res.adc_start = 1'b1;
            end
          end
        end
      end
      REQ_SOUND, REQ_TUNE: begin
        if (!pat_ok) begin
          status = ST_INVALID;
        end else if (!buzzer_enabled || playing) begin
          status = ST_BUSY;
        end else if (pat.duty == 8'd0 || pat.duty >= DUTY_LIMIT || pat.on_ms == 16'd0 ||
                     pat.off_ms == 16'd0 || pat.rep == 16'd0) begin
          status = ST_INVALID;
        end else begin
          playing_next       = 1'b1;
          next_is_burst_next = 1'b0;
          held_duty_next     = pat.duty[6:0];
          held_freq_next     = pat.freq;
          held_on_ms_next    = pat.on_ms;
          held_off_ms_next   = pat.off_ms;
          bursts_done_next   = '0;
          burst_limit_next   = pat.rep;
          held_prod_next     = 32'(pat.freq) * 32'(pat.on_ms);
          ms_left_next       = TIME_BITS'(START_DELAY_MS);
        end
      end
      default: begin
      end
    endcase

    res.status       = status;
    res.busy_res     = playing_next;
    res.power_enable = playing_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      next_is_burst <= 1'b0;
      ms_left       <= '0;
      bursts_done   <= '0;
      burst_limit   <= '0;
    end else if (advance) begin
      playing       <= playing_next;
      next_is_burst <= next_is_burst_next;
      ms_left       <= ms_left_next;
      bursts_done   <= bursts_done_next;
      burst_limit   <= burst_limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_duty   <= held_duty_next;
      held_freq   <= held_freq_next;
      held_on_ms  <= held_on_ms_next;
      held_off_ms <= held_off_ms_next;
      held_prod   <= held_prod_next;
    end
  end

endmodule

// ===== src/beep_burst_sequencer_core.sv =====
// Top level of the beep burst sequencer: input register, update logic, result register.
// A beat passes from the input register to the result register. Throughput: one beat
// per cycle unless res_out.ready stalls; the two registers form a two-stage pipe, so a
// new beat can still enter an empty input register while a finished result waits.
// The burst cycle count is ready from its multiply register before any burst can fire.
// Reset (rst, synchronous) clears the pipe, stops any pattern and sets buzzer_enabled.
module beep_burst_sequencer_core import bbs_pkg::*; #(
  parameter int START_DELAY_MS = 10,
  parameter int TIME_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  bbs_chan_if.sink    req_in,
  bbs_chan_if.source  res_out,
  bbs_chan_if.sink    cfg
);

  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  result_t     out_res;
  logic        advance;
  logic        buzzer_enabled;
  result_t     step_res;
  logic [31:0] held_prod;
  logic [22:0] cycles;

  assign advance      = in_valid && (!out_valid || res_out.ready);
  assign req_in.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;
  assign res_out.valid = out_valid;
  assign res_out.data  = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_in.ready) begin
        in_valid <= req_in.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_in.valid && req_in.ready) begin
      in_item <= req_in.data;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer_enabled <= 1'b1;
    end else if (cfg.valid) begin
      buzzer_enabled <= cfg.data;
    end
  end

  bbs_seq #(
    .START_DELAY_MS(START_DELAY_MS),
    .TIME_BITS(TIME_BITS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .item(in_item),
    .buzzer_enabled(buzzer_enabled),
    .cycles(cycles),
    .held_prod(held_prod),
    .res(step_res)
  );

  bbs_cycles u_cycles (
    .clk(clk),
    .held_prod(held_prod),
    .cycles(cycles)
  );

endmodule

// ===== src/bbs_checker.sv =====
// Port-level checks of the beep burst sequencer and their binding.
`include "beep_burst_sequencer_core_assert.svh"

module bbs_checker import bbs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input result_t out_data
);

  logic burst_fields_zero;
  logic pulse_seen;

  assign burst_fields_zero = out_data.pwm_cycles == '0 && out_data.pwm_duty == '0 &&
                             out_data.pwm_freq == '0;
  assign pulse_seen        = out_data.pwm_fire || out_data.adc_start;

  `BBS_ASSERT_NOW(a_power_follows_busy, out_valid, out_data.power_enable == out_data.busy_res)
  `BBS_ASSERT_NOW(a_fire_adc_apart, out_valid && out_data.pwm_fire, !out_data.adc_start)
  `BBS_ASSERT_NOW(a_adc_ends_play, out_valid && out_data.adc_start, !out_data.busy_res)
  `BBS_ASSERT_NOW(a_idle_fields_zero, out_valid && !out_data.pwm_fire, burst_fields_zero)
  `BBS_ASSERT_NOW(a_event_status_ok, out_valid && pulse_seen, out_data.status == ST_OK)

endmodule

bind beep_burst_sequencer_core bbs_checker u_bbs_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(res_out.valid),
  .out_data(res_out.data)
);
